FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, masked during reset
`define ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// implication into the next cycle, always checked
`define ASSERT_NXT(label, clk, a, b) \
  label: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/pfde_pkg.sv
// ----------------------------------------------------------------------------
// pfde_pkg
// Types, codes and font table for the frame store draw engine.
// ----------------------------------------------------------------------------
`default_nettype none

package pfde_pkg;

  localparam int unsigned COLUMNS_DEF = 128;
  localparam int unsigned PAGES_DEF   = 8;

  localparam logic [2:0] CMD_CLEAR = 3'd0;
  localparam logic [2:0] CMD_PIXEL = 3'd1;
  localparam logic [2:0] CMD_CHAR  = 3'd2;
  localparam logic [2:0] CMD_HEART = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  localparam logic [2:0] OP_NOP   = 3'd0;
  localparam logic [2:0] OP_CLEAR = 3'd1;
  localparam logic [2:0] OP_PIXEL = 3'd2;
  localparam logic [2:0] OP_CHAR  = 3'd3;
  localparam logic [2:0] OP_HEART = 3'd4;
  localparam logic [2:0] OP_READ  = 3'd5;

  localparam logic [5:0] DIGIT_BASE = 6'd26;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] x;
    logic [6:0] y;
    logic [5:0] glyph;
    logic       digit;
    logic [6:0] size;
    logic [9:0] ridx;
  } pfde_cmd_t;

  typedef struct packed {
    logic      valid;
    pfde_cmd_t cmd;
  } pfde_head_t;

  // column c sits at bits [8c+7:8c]
  function automatic logic [39:0] glyph_bits(input logic [5:0] g);
    logic [39:0] v;
    case (g)
      6'd0:  v = 40'h7E1111117E;
      6'd1:  v = 40'h364949497F;
      6'd2:  v = 40'h224141413E;
      6'd3:  v = 40'h1C2241417F;
      6'd4:  v = 40'h414949497F;
      6'd5:  v = 40'h010909097F;
      6'd6:  v = 40'h7A4949413E;
      6'd7:  v = 40'h7F0808087F;
      6'd8:  v = 40'h00417F4100;
      6'd9:  v = 40'h013F414020;
      6'd10: v = 40'h412214087F;
      6'd11: v = 40'h404040407F;
      6'd12: v = 40'h7F020C027F;
      6'd13: v = 40'h7F1008047F;
      6'd14: v = 40'h3E4141413E;
      6'd15: v = 40'h060909097F;
      6'd16: v = 40'h5E2151413E;
      6'd17: v = 40'h462919097F;
      6'd18: v = 40'h3149494946;
      6'd19: v = 40'h01017F0101;
      6'd20: v = 40'h3F4040403F;
      6'd21: v = 40'h1F2040201F;
      6'd22: v = 40'h3F4038403F;
      6'd23: v = 40'h6314081463;
      6'd24: v = 40'h0708700807;
      6'd25: v = 40'h4345495161;
      6'd26: v = 40'h3E5149453E;
      6'd27: v = 40'h00017F2100;
      6'd28: v = 40'h3149454321;
      6'd29: v = 40'h4669514142;
      6'd30: v = 40'h047F24140C;
      6'd31: v = 40'h4E51515172;
      6'd32: v = 40'h064949291E;
      6'd33: v = 40'h6050484740;
      6'd34: v = 40'h3649494936;
      6'd35: v = 40'h3C4A494930;
      default: v = 40'h0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] bit_rev8(input logic [7:0] a);
    logic [7:0] v;
    for (int b = 0; b < 8; b++) v[b] = a[7-b];
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pfde_req_if.sv
// ----------------------------------------------------------------------------
// pfde_req_if / pfde_rsp_if
// Request and response channels of the draw engine.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfde_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] x_pos;
  logic [6:0] y_pos;
  logic [7:0] char_code;
  logic [6:0] heart_size;
  logic [9:0] read_index;
  modport source (output valid, command, x_pos, y_pos, char_code, heart_size,
                  read_index, input ready);
  modport sink (input valid, command, x_pos, y_pos, char_code, heart_size,
                read_index, output ready);
endinterface

interface pfde_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  modport source (output valid, pixel_byte, input ready);
  modport sink (input valid, pixel_byte, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/page_framebuffer_draw_engine_top.sv
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine_top
// Page-organized monochrome frame store with a drawing command engine.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one request per valid/ready handshake: clear, set pixel,
//          draw double-scale character, draw heart or read byte.
//   out_ch returns exactly one pixel_byte per request, in request order;
//          it is the stored byte for a read and zero otherwise.
//   A two-entry queue sits between the decoder and the executor, and the
//          result sits in an output register, so requests are taken while
//          an earlier result waits.
//   Each request runs to completion before the next is popped: a character
//          visits every font sample, a heart every point of its size by
//          size square, and clear every byte of the store; each plotted
//          pixel inside the store is a read-modify-write of its byte.
//   Reset: synchronous, active low; afterwards every byte of the store is
//          swept to zero while in_ch.ready stays low.
//   A stalled receiver holds its result; the executor then waits in its
//          final step and the queue fills, dropping in_ch.ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module page_framebuffer_draw_engine_top
  import pfde_pkg::*;
#(
  parameter int unsigned COLUMNS = COLUMNS_DEF,
  parameter int unsigned PAGES   = PAGES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pfde_req_if.sink   in_ch,
  pfde_rsp_if.source out_ch
);

  pfde_head_t head;
  logic       pop;
  logic       init_busy;

  pfde_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .init_busy (init_busy),
    .in_ch     (in_ch),
    .pop       (pop),
    .head      (head)
  );

  pfde_back #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .init_busy (init_busy),
    .out_ch    (out_ch)
  );

  `ASSERT_IMP(a_init_blocks_req, clk, rst_n, init_busy, !in_ch.ready)
  `ASSERT_IMP(a_pop_has_head, clk, rst_n, pop, head.valid)
  `ASSERT_NXT(a_reset_starts_sweep, clk, !rst_n, init_busy)

endmodule

`default_nettype wire

FILE: hw/rtl/pfde_front.sv
// ----------------------------------------------------------------------------
// pfde_front
// Accepts requests, decodes them into operations, queues two deep.
// ----------------------------------------------------------------------------
`default_nettype none

module pfde_front
  import pfde_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   init_busy,
  pfde_req_if.sink    in_ch,
  input  wire logic   pop,
  output pfde_head_t  head
);

  pfde_cmd_t  q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  pfde_cmd_t  dec;
  logic       push;

  always_comb begin
    dec.x     = in_ch.x_pos;
    dec.y     = in_ch.y_pos;
    dec.size  = in_ch.heart_size;
    dec.ridx  = in_ch.read_index;
    dec.glyph = '0;
    dec.digit = 1'b0;
    dec.op    = OP_NOP;
    case (in_ch.command)
      CMD_CLEAR: dec.op = OP_CLEAR;
      CMD_PIXEL: dec.op = OP_PIXEL;
      CMD_CHAR: begin
        if (in_ch.char_code inside {[8'h41:8'h5A]}) begin
          dec.op    = OP_CHAR;
          dec.glyph = 6'(in_ch.char_code - 8'h41);
        end else if (in_ch.char_code inside {[8'h30:8'h39]}) begin
          dec.op    = OP_CHAR;
          dec.digit = 1'b1;
          dec.glyph = DIGIT_BASE + 6'(in_ch.char_code - 8'h30);
        end
      end
      CMD_HEART: begin
        if (in_ch.heart_size != 7'd0) dec.op = OP_HEART;
      end
      CMD_READ:  dec.op = OP_READ;
      default:   dec.op = OP_NOP;
    endcase
  end

  assign in_ch.ready = !init_busy && (count_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign head.valid  = (count_r != 2'd0);
  assign head.cmd    = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= dec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pfde_back.sv
// ----------------------------------------------------------------------------
// pfde_back
// Executes queued operations on the frame store, one pixel at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module pfde_back
  import pfde_pkg::*;
#(
  parameter int unsigned COLUMNS = COLUMNS_DEF,
  parameter int unsigned PAGES   = PAGES_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  pfde_head_t  head,
  output logic        pop,
  output logic        init_busy,
  pfde_rsp_if.source  out_ch
);

  localparam int unsigned STORE = COLUMNS * PAGES;
  localparam int unsigned AW    = $clog2(STORE);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CLR   = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_WR    = 4'd4;
  localparam logic [3:0] S_CHR   = 4'd5;
  localparam logic [3:0] S_HSET1 = 4'd6;
  localparam logic [3:0] S_HSET2 = 4'd7;
  localparam logic [3:0] S_HSQ   = 4'd8;
  localparam logic [3:0] S_HTST  = 4'd9;
  localparam logic [3:0] S_RREQ  = 4'd10;
  localparam logic [3:0] S_RDAT  = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  logic [7:0]    mem [STORE];
  logic [7:0]    rd_data_r;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [7:0]    wr_data;

  logic [3:0]    state_r, ret_r;
  pfde_cmd_t     cmd_r;
  logic [AW-1:0] clr_cnt_r;
  logic [8:0]    px_r;
  logic [7:0]    py_r;
  logic [2:0]    col_r, row_r;
  logic [1:0]    sub_r;
  logic [6:0]    i_r, j_r;
  logic [5:0]    h_r, t_r;
  logic [13:0]   ss_r;
  logic [11:0]   r_r;
  logic [15:0]   sq_dx_r, sq_dxt_r, sq_dy_r;
  logic          tri_r;
  logic [7:0]    result_r;
  logic          out_valid_r;
  logic [7:0]    out_byte_r;

  logic [15:0]   idx;
  logic          idx_ok;
  logic [15:0]   ridx_w;
  logic          ridx_ok;
  logic [39:0]   gbits;
  logic [7:0]    gline;
  logic          char_last, heart_last;
  logic signed [8:0] dx, dy, dxt;
  logic [7:0]    adx, adxt, ady;
  logic signed [9:0] hmd;
  logic [16:0]   sum_a, sum_b;
  logic          heart_hit;
  logic [12:0]   t_prod;
  logic [27:0]   r_prod;
  logic          fin_go;

  assign idx     = 16'(py_r >> 3) * 16'(COLUMNS) + 16'(px_r);
  assign idx_ok  = idx < 16'(STORE);
  assign ridx_w  = 16'(cmd_r.ridx);
  assign ridx_ok = ridx_w < 16'(STORE);

  assign gbits     = glyph_bits(cmd_r.glyph);
  assign gline     = cmd_r.digit ? bit_rev8(gbits[col_r*8 +: 8]) : gbits[col_r*8 +: 8];
  assign char_last = (col_r == 3'd4) && (row_r == 3'd7) && (sub_r == 2'd3);

  assign dx   = $signed({2'b00, i_r}) - $signed({3'b000, h_r});
  assign dy   = $signed({2'b00, j_r}) - $signed({3'b000, h_r});
  assign dxt  = dx - $signed({3'b000, t_r});
  assign adx  = dx[8] ? 8'(-dx) : dx[7:0];
  assign adxt = dxt[8] ? 8'(-dxt) : dxt[7:0];
  assign ady  = dy[8] ? 8'(-dy) : dy[7:0];
  assign hmd  = $signed({4'b0000, h_r}) - 10'(dy);
  assign sum_a = 17'(sq_dx_r) + 17'(sq_dy_r);
  assign sum_b = 17'(sq_dxt_r) + 17'(sq_dy_r);
  assign heart_hit = (sum_a < 17'(r_r)) || (sum_b < 17'(r_r)) || tri_r;
  assign heart_last = (i_r == cmd_r.size - 7'd1) && (j_r == cmd_r.size - 7'd1);
  assign t_prod = 13'(cmd_r.size) * 13'd43;
  assign r_prod = 28'(ss_r) * 28'd13108;
  assign fin_go = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  always_comb begin
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    rd_addr = idx[AW-1:0];
    wr_addr = idx[AW-1:0];
    wr_data = rd_data_r | (8'd1 << py_r[2:0]);
    case (state_r)
      S_INIT, S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_r;
        wr_data = 8'd0;
      end
      S_RD:   rd_en = idx_ok;
      S_WR:   wr_en = 1'b1;
      S_RREQ: begin
        rd_en   = ridx_ok;
        rd_addr = ridx_w[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign pop           = (state_r == S_IDLE) && head.valid;
  assign init_busy     = (state_r == S_INIT);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.pixel_byte = out_byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fin_go) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_INIT, S_CLR: begin
          if (clr_cnt_r == AW'(STORE - 1)) begin
            clr_cnt_r <= '0;
            state_r   <= (state_r == S_INIT) ? S_IDLE : S_FIN;
          end else begin
            clr_cnt_r <= clr_cnt_r + AW'(1);
          end
        end
        S_IDLE: begin
          if (head.valid) begin
            cmd_r    <= head.cmd;
            result_r <= 8'd0;
            px_r     <= 9'(head.cmd.x);
            py_r     <= 8'(head.cmd.y);
            ret_r    <= S_FIN;
            col_r    <= '0;
            row_r    <= '0;
            sub_r    <= '0;
            i_r      <= '0;
            j_r      <= '0;
            case (head.cmd.op)
              OP_CLEAR: state_r <= S_CLR;
              OP_PIXEL: state_r <= S_RD;
              OP_CHAR:  state_r <= S_CHR;
              OP_HEART: state_r <= S_HSET1;
              OP_READ:  state_r <= S_RREQ;
              default:  state_r <= S_FIN;
            endcase
          end
        end
        S_RD:  state_r <= idx_ok ? S_WR : ret_r;
        S_WR:  state_r <= ret_r;
        S_CHR: begin
          sub_r <= sub_r + 2'd1;
          if (sub_r == 2'd3) begin
            row_r <= row_r + 3'd1;
            if (row_r == 3'd7) col_r <= col_r + 3'd1;
          end
          px_r <= 9'(cmd_r.x) + 9'({col_r, 1'b0}) + 9'(sub_r[0]);
          py_r <= 8'(cmd_r.y) + 8'({row_r, 1'b0}) + 8'(sub_r[1]);
          ret_r <= char_last ? S_FIN : S_CHR;
          if (gline[row_r]) state_r <= S_RD;
          else if (char_last) state_r <= S_FIN;
        end
        S_HSET1: begin
          ss_r    <= 14'(cmd_r.size) * 14'(cmd_r.size);
          h_r     <= 6'(cmd_r.size >> 1);
          t_r     <= 6'(t_prod >> 7);
          state_r <= S_HSET2;
        end
        S_HSET2: begin
          r_r     <= 12'(r_prod >> 16);
          state_r <= S_HSQ;
        end
        S_HSQ: begin
          sq_dx_r  <= 16'(adx) * 16'(adx);
          sq_dxt_r <= 16'(adxt) * 16'(adxt);
          sq_dy_r  <= 16'(ady) * 16'(ady);
          tri_r    <= !dy[8] && (dy != 9'sd0) && ($signed({2'b00, adx}) < hmd);
          px_r     <= 9'(cmd_r.x) + 9'(i_r);
          py_r     <= 8'(cmd_r.y) + 8'(j_r);
          state_r  <= S_HTST;
        end
        S_HTST: begin
          if (j_r == cmd_r.size - 7'd1) begin
            j_r <= '0;
            i_r <= i_r + 7'd1;
          end else begin
            j_r <= j_r + 7'd1;
          end
          ret_r <= heart_last ? S_FIN : S_HSQ;
          if (heart_hit) state_r <= S_RD;
          else state_r <= heart_last ? S_FIN : S_HSQ;
        end
        S_RREQ: state_r <= ridx_ok ? S_RDAT : S_FIN;
        S_RDAT: begin
          result_r <= rd_data_r;
          state_r  <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            out_byte_r  <= result_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the frame store draw engine: a shadow frame store
// predicts every response byte; requests and responses idle in random bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import pfde_pkg::*;

  localparam int unsigned STORE_BYTES = COLUMNS_DEF * PAGES_DEF;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] x_pos;
    logic [6:0] y_pos;
    logic [7:0] char_code;
    logic [6:0] heart_size;
    logic [9:0] read_index;
  } draw_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pfde_req_if req_ch ();
  pfde_rsp_if rsp_ch ();

  page_framebuffer_draw_engine_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch.sink),
    .out_ch (rsp_ch.source)
  );

  always #5 clk = ~clk;

  logic [7:0] shadow_store [STORE_BYTES];
  draw_req_t  pending_reqs [$];
  logic [7:0] expected_bytes [$];
  int         req_gap;
  int         rsp_gap;
  bit         quiet_tail;
  bit         hold_sender;
  int         errors;
  int         reads_checked;

  function automatic logic [7:0] font_column(input int g, input int col);
    logic [39:0] bits;
    case (g)
      0:  bits = 40'h7E1111117E;  1:  bits = 40'h364949497F;
      2:  bits = 40'h224141413E;  3:  bits = 40'h1C2241417F;
      4:  bits = 40'h414949497F;  5:  bits = 40'h010909097F;
      6:  bits = 40'h7A4949413E;  7:  bits = 40'h7F0808087F;
      8:  bits = 40'h00417F4100;  9:  bits = 40'h013F414020;
      10: bits = 40'h412214087F;  11: bits = 40'h404040407F;
      12: bits = 40'h7F020C027F;  13: bits = 40'h7F1008047F;
      14: bits = 40'h3E4141413E;  15: bits = 40'h060909097F;
      16: bits = 40'h5E2151413E;  17: bits = 40'h462919097F;
      18: bits = 40'h3149494946;  19: bits = 40'h01017F0101;
      20: bits = 40'h3F4040403F;  21: bits = 40'h1F2040201F;
      22: bits = 40'h3F4038403F;  23: bits = 40'h6314081463;
      24: bits = 40'h0708700807;  25: bits = 40'h4345495161;
      26: bits = 40'h3E5149453E;  27: bits = 40'h00017F2100;
      28: bits = 40'h3149454321;  29: bits = 40'h4669514142;
      30: bits = 40'h047F24140C;  31: bits = 40'h4E51515172;
      32: bits = 40'h064949291E;  33: bits = 40'h6050484740;
      34: bits = 40'h3649494936;  35: bits = 40'h3C4A494930;
      default: bits = 40'h0;
    endcase
    return bits[col*8 +: 8];
  endfunction

  function automatic void shadow_plot(input int unsigned px, input int unsigned py);
    int unsigned idx;
    idx = (py / 8) * COLUMNS_DEF + px;
    if (idx < STORE_BYTES) shadow_store[idx][py % 8] = 1'b1;
  endfunction

  function automatic logic [7:0] predict_byte(input draw_req_t r);
    int g, s, h, t, rr, dx, dy, adx;
    logic [7:0] line, flipped;
    bit digit;
    logic [7:0] res;
    res = 8'h00;
    case (r.command)
      CMD_CLEAR: foreach (shadow_store[k]) shadow_store[k] = 8'h00;
      CMD_PIXEL: shadow_plot(r.x_pos, r.y_pos);
      CMD_CHAR: begin
        g = -1;
        digit = 1'b0;
        if (r.char_code >= "A" && r.char_code <= "Z") g = r.char_code - "A";
        else if (r.char_code >= "0" && r.char_code <= "9") begin
          g = 26 + r.char_code - "0";
          digit = 1'b1;
        end
        if (g >= 0) begin
          for (int col = 0; col < 5; col++) begin
            line = font_column(g, col);
            if (digit) begin
              for (int b = 0; b < 8; b++) flipped[b] = line[7-b];
              line = flipped;
            end
            for (int row = 0; row < 8; row++) begin
              if (line[row]) begin
                shadow_plot(r.x_pos + 2*col, r.y_pos + 2*row);
                shadow_plot(r.x_pos + 2*col + 1, r.y_pos + 2*row);
                shadow_plot(r.x_pos + 2*col, r.y_pos + 2*row + 1);
                shadow_plot(r.x_pos + 2*col + 1, r.y_pos + 2*row + 1);
              end
            end
          end
        end
      end
      CMD_HEART: begin
        s = r.heart_size;
        h = s / 2;
        t = s / 3;
        rr = (s * s) / 5;
        for (int i = 0; i < s; i++) begin
          for (int j = 0; j < s; j++) begin
            dx = i - h;
            dy = j - h;
            adx = dx < 0 ? -dx : dx;
            if (dx*dx + dy*dy < rr || (dx-t)*(dx-t) + dy*dy < rr ||
                (dy > 0 && adx < h - dy))
              shadow_plot(r.x_pos + i, r.y_pos + j);
          end
        end
      end
      CMD_READ: if (r.read_index < STORE_BYTES) res = shadow_store[r.read_index];
      default: ;
    endcase
    return res;
  endfunction

  function automatic draw_req_t make_req(input logic [2:0] c, input int x, input int y,
                                         input int code, input int sz, input int ri);
    draw_req_t r;
    r.command = c;
    r.x_pos = 8'(x);
    r.y_pos = 7'(y);
    r.char_code = 8'(code);
    r.heart_size = 7'(sz);
    r.read_index = 10'(ri);
    return r;
  endfunction

  function automatic draw_req_t random_req();
    draw_req_t r;
    int sel;
    r = make_req($urandom_range(7, 0), $urandom_range(255, 0), $urandom_range(127, 0),
                 $urandom_range(255, 0), $urandom_range(127, 0), $urandom_range(1023, 0));
    sel = $urandom_range(99, 0);
    if (sel < 40) r.command = CMD_READ;
    else if (sel < 65) r.command = CMD_PIXEL;
    else if (sel < 80) begin
      r.command = CMD_CHAR;
      case ($urandom_range(2, 0))
        0: r.char_code = 8'($urandom_range("Z", "A"));
        1: r.char_code = 8'($urandom_range("9", "0"));
        default: ;
      endcase
    end else if (sel < 90) begin
      r.command = CMD_HEART;
      r.heart_size = 7'(($urandom_range(9, 0) == 0) ? $urandom_range(127, 0)
                                                    : $urandom_range(16, 0));
    end else if (sel < 92) r.command = CMD_CLEAR;
    if (r.command == CMD_READ && $urandom_range(1, 0))
      r.read_index = 10'((r.y_pos / 8) * COLUMNS_DEF + r.x_pos);
    return r;
  endfunction

  function automatic draw_req_t req_ch_payload();
    return make_req(req_ch.command, req_ch.x_pos, req_ch.y_pos, req_ch.char_code,
                    req_ch.heart_size, req_ch.read_index);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      req_gap <= 0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (req_ch.valid) expected_bytes.push_back(predict_byte(req_ch_payload()));
      if (req_gap > 0) begin
        req_gap <= req_gap - 1;
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() > 0 && !(hold_sender &&
                   (expected_bytes.size() > 0 || req_ch.valid))) begin
        {req_ch.command, req_ch.x_pos, req_ch.y_pos, req_ch.char_code,
         req_ch.heart_size, req_ch.read_index} <= pending_reqs.pop_front();
        req_ch.valid <= 1'b1;
        if (!quiet_tail && $urandom_range(9, 0) == 0) req_gap <= $urandom_range(19, 1);
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
      rsp_gap <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected response pixel_byte=%0h", rsp_ch.pixel_byte);
          errors++;
        end else begin
          if (rsp_ch.pixel_byte !== expected_bytes[0]) begin
            $error("pixel_byte expected %0h actual %0h", expected_bytes[0],
                   rsp_ch.pixel_byte);
            errors++;
          end
          if (expected_bytes[0] != 0) reads_checked++;
          void'(expected_bytes.pop_front());
        end
      end
      if (rsp_gap > 0) begin
        rsp_gap <= rsp_gap - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (!quiet_tail && $urandom_range(9, 0) == 0) rsp_gap <= $urandom_range(19, 1);
      end
    end
  end

  initial begin
    #200_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.command = CMD_CLEAR;
    req_ch.x_pos = '0;
    req_ch.y_pos = '0;
    req_ch.char_code = '0;
    req_ch.heart_size = '0;
    req_ch.read_index = '0;
    rsp_ch.ready = 1'b0;
    errors = 0;
    reads_checked = 0;
    quiet_tail = 1'b0;
    hold_sender = 1'b0;
    foreach (shadow_store[k]) shadow_store[k] = 8'h00;

    pending_reqs.push_back(make_req(CMD_READ, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(CMD_PIXEL, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(CMD_PIXEL, 255, 127, 255, 127, 1023));
    pending_reqs.push_back(make_req(CMD_PIXEL, 200, 7, 0, 0, 0));
    pending_reqs.push_back(make_req(CMD_READ, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(CMD_READ, 0, 0, 0, 0, 200));
    pending_reqs.push_back(make_req(CMD_READ, 0, 0, 0, 0, 1023));
    pending_reqs.push_back(make_req(CMD_CHAR, 10, 0, "A", 0, 0));
    pending_reqs.push_back(make_req(CMD_CHAR, 30, 8, "Z", 0, 0));
    pending_reqs.push_back(make_req(CMD_CHAR, 50, 16, "0", 0, 0));
    pending_reqs.push_back(make_req(CMD_CHAR, 250, 120, "9", 0, 0));
    pending_reqs.push_back(make_req(CMD_CHAR, 70, 0, "a", 0, 0));
    pending_reqs.push_back(make_req(CMD_READ, 0, 0, 0, 0, 10));
    pending_reqs.push_back(make_req(CMD_READ, 0, 0, 0, 0, 178));
    pending_reqs.push_back(make_req(CMD_HEART, 0, 40, 0, 0, 0));
    pending_reqs.push_back(make_req(CMD_HEART, 60, 60, 0, 16, 0));
    pending_reqs.push_back(make_req(CMD_HEART, 200, 100, 0, 127, 0));
    pending_reqs.push_back(make_req(CMD_READ, 0, 0, 0, 0, 1000));
    pending_reqs.push_back(make_req(3'd5, 1, 1, 1, 1, 1));
    pending_reqs.push_back(make_req(3'd7, 255, 127, 255, 127, 1023));
    pending_reqs.push_back(make_req(CMD_CLEAR, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(CMD_READ, 0, 0, 0, 0, 1000));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int n = 0; n < 1000; n++) pending_reqs.push_back(random_req());
    wait (pending_reqs.size() < 500);
    @(posedge clk);
    hold_sender <= 1'b1;
    wait (pending_reqs.size() < 495);
    @(posedge clk);
    hold_sender <= 1'b0;
    wait (pending_reqs.size() < 100);
    @(posedge clk);
    quiet_tail <= 1'b1;
    wait (pending_reqs.size() == 0 && !req_ch.valid && expected_bytes.size() == 0);
    repeat (50) @(posedge clk);

    $display("Ran 1022 requests over all commands; %0d nonzero read bytes matched",
             reads_checked);
    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
